// File: hdl/afmt_pkg.sv
// ----------------------------------------------------------------------------
// Altitude flight-mode throttle package
// Field widths, fixed constants, flight modes and the control word of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
package afmt_pkg;

  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned DIST_W     = 11;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned HOVER_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CEILING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOVER_ITEMS   = 3'd4;

  localparam logic [DIST_W-1:0]  RST_SWITCH_HEIGHT = 11'd480;
  localparam logic [DIST_W-1:0]  RST_KILL_HEIGHT   = 11'd960;
  localparam logic [DIST_W-1:0]  RST_VALID_LIMIT   = 11'd1600;
  localparam logic [WIDTH_W-1:0] RST_WIDTH_CEILING = 16'd9000;
  localparam logic [HOVER_W-1:0] RST_HOVER_ITEMS   = 8'd20;

  localparam logic [DIST_W-1:0]  TICKS_PER_CM = 11'd592;
  localparam logic [11:0]        TAKEOFF_GAIN = 12'd3000;
  localparam logic [WIDTH_W-1:0] BASE_WIDTH   = 16'd6000;
  localparam logic [5:0]         LAND_SLOPE   = 6'd35;
  localparam logic [WIDTH_W-1:0] LAND_BASE    = 16'd5600;
  localparam logic [WIDTH_W-1:0] KILL_WIDTH   = 16'd4500;
  localparam logic [HOVER_W-1:0] HOVER_MAX    = 8'd255;

  // Ticks per cm is 37 shifted left by four. The division by 37 is a multiply
  // by the rounded-up reciprocal, exact for numerators below 2**20.
  localparam int unsigned            CM_PRE_SHIFT   = 4;
  localparam int unsigned            CM_RECIP_W     = 21;
  localparam int unsigned            CM_RECIP_SHIFT = 26;
  localparam logic [CM_RECIP_W-1:0]  CM_RECIP       = 21'd1813754;

  typedef enum logic [1:0] {
    MODE_TAKEOFF = 2'd0,
    MODE_HOVER   = 2'd1,
    MODE_LANDING = 2'd2
  } mode_t;

  // Condition that holds a step or sends it to its jump target.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_NOT_TAKEOFF,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              accept;
    logic              load_gain;
    logic              take_dist;
    logic              finish;
    logic              last;
  } ctrl_word_t;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_ACCEPT    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MEAS_WAIT = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIST      = 3'd2;
  localparam logic [STEP_W-1:0] STEP_GAIN      = 3'd3;
  localparam logic [STEP_W-1:0] STEP_GAIN_WAIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_WIDTH     = 3'd5;

endpackage

// File: hdl/afmt_ucode_rom.sv
// ----------------------------------------------------------------------------
// Altitude flight-mode throttle control store
// Read-only program of the sequencer: one control word per step.
// ----------------------------------------------------------------------------
module afmt_ucode_rom (
  input  logic [afmt_pkg::STEP_W-1:0] step,
  output afmt_pkg::ctrl_word_t        ctrl
);
  import afmt_pkg::*;

  always_comb begin
    ctrl = '{cond: COND_NONE, target: STEP_ACCEPT, accept: 1'b0, load_gain: 1'b0,
             take_dist: 1'b0, finish: 1'b0, last: 1'b0};
    case (step)
      STEP_ACCEPT: begin
        // Wait for a request, then capture the echo width.
        ctrl.cond   = COND_NO_INPUT;
        ctrl.target = STEP_ACCEPT;
        ctrl.accept = 1'b1;
      end
      STEP_MEAS_WAIT: begin
        // Wait while the reciprocal product is registered.
        ctrl.cond   = COND_NONE;
      end
      STEP_DIST: begin
        ctrl.take_dist = 1'b1;
      end
      STEP_GAIN: begin
        // Only takeoff needs the gain quotient.
        ctrl.cond      = COND_NOT_TAKEOFF;
        ctrl.target    = STEP_WIDTH;
        ctrl.load_gain = 1'b1;
      end
      STEP_GAIN_WAIT: begin
        ctrl.cond   = COND_DIV_BUSY;
        ctrl.target = STEP_GAIN_WAIT;
      end
      STEP_WIDTH: begin
        ctrl.cond   = COND_OUT_BLOCKED;
        ctrl.target = STEP_WIDTH;
        ctrl.finish = 1'b1;
        ctrl.last   = 1'b1;
      end
      default: begin
        ctrl.cond   = COND_NONE;
        ctrl.last   = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/afmt_div.sv
// ----------------------------------------------------------------------------
// Altitude flight-mode throttle divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module afmt_div #(
  parameter int unsigned NUM_W = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NUM_W-1:0]            dividend,
  input  logic [afmt_pkg::DIST_W-1:0] divisor,
  output logic                        busy,
  output logic [NUM_W-1:0]            quotient
);
  import afmt_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  count;
  logic [DIST_W-1:0] rem;
  logic [DIST_W-1:0] dvsr;
  logic [DIST_W:0]   trial;
  logic              fits;

  assign busy  = (count != '0);
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // The remainder stays below the divisor, so it fits in DIST_W bits.
      if (fits) begin
        rem <= DIST_W'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[DIST_W-1:0];
      end
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

// File: hdl/altitude_flight_mode_throttle.sv
// ----------------------------------------------------------------------------
// Altitude flight-mode throttle: echo width to PWM high time per flight mode.
// One request at a time: a new echo is accepted only after the last result is
// issued, and in takeoff only after the one-bit-per-cycle divider has produced
// the gain quotient.
// Synchronous reset returns to takeoff with all history cleared.
// ----------------------------------------------------------------------------
module altitude_flight_mode_throttle #(
  parameter int unsigned DIST_FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            echo_valid,
  output logic                            echo_stall,
  input  logic [afmt_pkg::TICKS_W-1:0]    echo_ticks,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [afmt_pkg::WIDTH_W-1:0]    high_width,
  output logic [1:0]                      mode,
  output logic [afmt_pkg::DIST_W-1:0]     distance,
  output logic                            rejected,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [afmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afmt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import afmt_pkg::*;

  localparam int unsigned NUM_W  = TICKS_W + DIST_FRAC_BITS;
  localparam int unsigned CALC_W = NUM_W + 2;
  localparam int unsigned PROD_W = NUM_W + CM_RECIP_W;
  localparam int unsigned MEAS_W = PROD_W - CM_RECIP_SHIFT;

  logic [DIST_W-1:0]  switch_height;
  logic [DIST_W-1:0]  kill_height;
  logic [DIST_W-1:0]  valid_limit;
  logic [WIDTH_W-1:0] width_ceiling;
  logic [HOVER_W-1:0] hover_items;

  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_next;
  ctrl_word_t         ctrl;
  logic               cond_true;
  logic               act;

  mode_t              flight_mode;
  mode_t              flight_mode_next;
  logic [DIST_W-1:0]  last_distance;
  logic [WIDTH_W-1:0] last_width;
  logic [HOVER_W-1:0] hover_count;
  logic [HOVER_W-1:0] hover_count_next;
  logic               rejected_now;

  logic [TICKS_W-1:0] echo_hold;
  logic [NUM_W-1:0]   meas_scaled;
  logic [PROD_W-1:0]  meas_prod;
  logic [MEAS_W-1:0]  measured;
  logic               meas_rejected;

  logic               div_start;
  logic [NUM_W-1:0]   div_dividend;
  logic [DIST_W-1:0]  div_divisor;
  logic               div_busy;
  logic [NUM_W-1:0]   div_quotient;

  logic [CALC_W-1:0]  land_prod;
  logic [CALC_W-1:0]  calc_width;
  logic               hold;
  logic               kill;
  logic [WIDTH_W-1:0] width_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_height <= RST_SWITCH_HEIGHT;
      kill_height   <= RST_KILL_HEIGHT;
      valid_limit   <= RST_VALID_LIMIT;
      width_ceiling <= RST_WIDTH_CEILING;
      hover_items   <= RST_HOVER_ITEMS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SWITCH_HEIGHT: switch_height <= cfg_data[DIST_W-1:0];
        REG_KILL_HEIGHT:   kill_height   <= cfg_data[DIST_W-1:0];
        REG_VALID_LIMIT:   valid_limit   <= cfg_data[DIST_W-1:0];
        REG_WIDTH_CEILING: width_ceiling <= cfg_data[WIDTH_W-1:0];
        REG_HOVER_ITEMS:   hover_items   <= cfg_data[HOVER_W-1:0];
        default: ;
      endcase
    end
  end

  afmt_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      COND_NONE:        cond_true = 1'b0;
      COND_NO_INPUT:    cond_true = !echo_valid;
      COND_DIV_BUSY:    cond_true = div_busy;
      COND_NOT_TAKEOFF: cond_true = (flight_mode != MODE_TAKEOFF);
      COND_OUT_BLOCKED: cond_true = result_valid && result_stall;
      default:          cond_true = 1'b0;
    endcase
  end

  // A step's actions fire on the cycle its condition releases it.
  assign act        = !cond_true;
  assign echo_stall = !ctrl.accept;
  assign step_next  = cond_true ? ctrl.target :
                      (ctrl.last ? STEP_ACCEPT : step + 1'b1);

  // Distance is (ticks << DIST_FRAC_BITS) / 592: drop the factor of 16 by a
  // shift, then divide by 37 through the reciprocal product.
  assign meas_scaled  = (NUM_W'(echo_hold) << DIST_FRAC_BITS) >> CM_PRE_SHIFT;
  assign measured     = meas_prod[PROD_W-1:CM_RECIP_SHIFT];
  assign rejected_now = (measured > MEAS_W'(valid_limit));

  always_ff @(posedge clk) begin
    meas_prod <= PROD_W'(meas_scaled) * PROD_W'(CM_RECIP);
  end

  assign div_start    = act && ctrl.load_gain;
  assign div_dividend = NUM_W'(TAKEOFF_GAIN) << DIST_FRAC_BITS;
  assign div_divisor  = last_distance;

  afmt_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Width for the current mode, then the kill and ceiling rules.
  always_comb begin
    land_prod        = CALC_W'(last_distance) * CALC_W'(LAND_SLOPE);
    flight_mode_next = flight_mode;
    hover_count_next = hover_count;
    hold             = 1'b0;
    calc_width       = CALC_W'(BASE_WIDTH);
    case (flight_mode)
      MODE_TAKEOFF: begin
        hold       = (last_distance == '0);
        calc_width = CALC_W'(div_quotient) + CALC_W'(BASE_WIDTH);
        if (last_distance > switch_height) begin
          flight_mode_next = MODE_HOVER;
          hover_count_next = '0;
          calc_width       = CALC_W'(BASE_WIDTH);
          hold             = 1'b0;
        end
      end
      MODE_HOVER: begin
        if (hover_count < HOVER_MAX) begin
          hover_count_next = hover_count + 1'b1;
        end
        if (hover_count_next >= hover_items) begin
          flight_mode_next = MODE_LANDING;
        end
      end
      default: begin
        calc_width = (land_prod >> DIST_FRAC_BITS) + CALC_W'(LAND_BASE);
      end
    endcase
    kill = (last_distance > kill_height);
    if (kill) begin
      calc_width = CALC_W'(KILL_WIDTH);
      hold       = 1'b0;
    end
    if (hold || calc_width > CALC_W'(width_ceiling)) begin
      width_next = last_width;
    end else begin
      width_next = calc_width[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_ACCEPT;
      flight_mode   <= MODE_TAKEOFF;
      last_distance <= '0;
      last_width    <= '0;
      hover_count   <= '0;
      result_valid  <= 1'b0;
    end else begin
      step <= step_next;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (act && ctrl.take_dist && !rejected_now) begin
        last_distance <= measured[DIST_W-1:0];
      end
      if (act && ctrl.finish) begin
        flight_mode  <= flight_mode_next;
        hover_count  <= hover_count_next;
        last_width   <= width_next;
        result_valid <= 1'b1;
      end
    end
  end

  // The previous result may still be waiting, so the outputs change only when
  // the new result is released.
  always_ff @(posedge clk) begin
    if (act && ctrl.accept) begin
      echo_hold <= echo_ticks;
    end
    if (act && ctrl.take_dist) begin
      meas_rejected <= rejected_now;
    end
    if (act && ctrl.finish) begin
      high_width <= width_next;
      mode       <= flight_mode_next;
      distance   <= last_distance;
      rejected   <= meas_rejected;
    end
  end

endmodule

// File: test/altitude_flight_mode_throttle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Altitude flight-mode throttle testbench
// A directed table walks the takeoff, hover and landing rules, the kill and
// ceiling overrides, rejected echoes and register masking. Random phases
// under several register settings follow. Each result is predicted or typed,
// then compared field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module altitude_flight_mode_throttle_test;
  import afmt_pkg::*;

  localparam int FRAC           = 4;
  localparam int TICKS_PER_STEP = 37;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 200;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE         = 60;
  localparam int LIMIT          = 2000000;
  localparam int PLAN_LEN       = 26;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [1:0]         mode;
    logic [DIST_W-1:0]  dist_used;
    logic               rej;
  } throttle_t;

  typedef enum logic {ROW_ECHO, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  known;
    throttle_t             res;
  } row_t;

  localparam throttle_t NO_TYPED = '0;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  echo_valid;
  logic                  echo_stall;
  logic [TICKS_W-1:0]    echo_ticks;
  logic                  result_valid;
  logic                  result_stall;
  logic [WIDTH_W-1:0]    high_width;
  logic [1:0]            mode;
  logic [DIST_W-1:0]     distance;
  logic                  rejected;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Register copies and flight state of the predictor.
  logic [DIST_W-1:0]  cfg_switch;
  logic [DIST_W-1:0]  cfg_kill;
  logic [DIST_W-1:0]  cfg_vlim;
  logic [WIDTH_W-1:0] cfg_ceiling;
  logic [HOVER_W-1:0] cfg_hover;
  mode_t              mode_now;
  logic [DIST_W-1:0]  dist_hold;
  logic [WIDTH_W-1:0] width_hold;
  logic [HOVER_W-1:0] hover_steps;

  throttle_t pending_cmds[$];
  throttle_t want_cmd;
  row_t      plan [0:PLAN_LEN-1];
  int        errors = 0;
  int        sent = 0;
  int        results_seen = 0;
  int        cycle_cnt = 0;
  bit        hold_off_req = 1'b0;

  altitude_flight_mode_throttle #(
    .DIST_FRAC_BITS(FRAC)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .echo_valid  (echo_valid),
    .echo_stall  (echo_stall),
    .echo_ticks  (echo_ticks),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .high_width  (high_width),
    .mode        (mode),
    .distance    (distance),
    .rejected    (rejected),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic throttle_t next_throttle(logic [TICKS_W-1:0] ticks);
    logic [31:0] measured;
    logic [31:0] dist32;
    logic [31:0] gain32;
    logic [31:0] width;
    logic        hold;
    throttle_t   r;
    measured = {16'd0, ticks};
    measured = (measured << FRAC) / 32'(TICKS_PER_CM);
    r.rej = (measured > 32'(cfg_vlim));
    if (!r.rej) begin
      dist_hold = measured[DIST_W-1:0];
    end
    dist32 = 32'(dist_hold);
    gain32 = 32'(TAKEOFF_GAIN);
    hold = 1'b0;
    width = '0;
    case (mode_now)
      MODE_TAKEOFF: begin
        if (dist32 == 0) begin
          hold = 1'b1;
        end else begin
          width = (gain32 << FRAC) / dist32 + 32'(BASE_WIDTH);
        end
        if (dist_hold > cfg_switch) begin
          mode_now = MODE_HOVER;
          hover_steps = '0;
          width = 32'(BASE_WIDTH);
          hold = 1'b0;
        end
      end
      MODE_HOVER: begin
        width = 32'(BASE_WIDTH);
        if (hover_steps != HOVER_MAX) begin
          hover_steps = hover_steps + 1'b1;
        end
        if (hover_steps >= cfg_hover) begin
          mode_now = MODE_LANDING;
        end
      end
      default: begin
        width = ((dist32 * 32'(LAND_SLOPE)) >> FRAC) + 32'(LAND_BASE);
      end
    endcase
    // Kill overrides the mode rules; the ceiling is applied last.
    if (dist_hold > cfg_kill) begin
      width = 32'(KILL_WIDTH);
      hold = 1'b0;
    end
    if (hold || width > 32'(cfg_ceiling)) begin
      width = 32'(width_hold);
    end
    width_hold = width[WIDTH_W-1:0];
    r.width = width_hold;
    r.mode = mode_now;
    r.dist_used = dist_hold;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 16);
    end
    return $urandom_range(40, 150);
  endfunction

  // Some echo widths cluster around the kill and valid-limit distances; others are extremes or uniform.
  function automatic logic [TICKS_W-1:0] pick_ticks();
    int                 center;
    int                 lo;
    int                 hi;
    logic [TICKS_W-1:0] t;
    center = -1;
    case ($urandom_range(0, 19))
      0: t = '0;
      1: t = '1;
      2, 3: center = cfg_kill * TICKS_PER_STEP;
      4, 5: center = cfg_vlim * TICKS_PER_STEP;
      default: begin
        hi = cfg_vlim * TICKS_PER_STEP + TICKS_PER_STEP - 1;
        if (hi > 65535 || $urandom_range(0, 3) == 0) begin
          hi = 65535;
        end
        t = TICKS_W'($urandom_range(0, hi));
      end
    endcase
    if (center >= 0) begin
      lo = (center > 80) ? center - 80 : 0;
      hi = (center + 80 > 65535) ? 65535 : center + 80;
      t = TICKS_W'($urandom_range(lo, hi));
    end
    return t;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_echo(logic [TICKS_W-1:0] ticks, logic known, throttle_t typed);
    int        gap;
    throttle_t predicted;
    gap = (((sent / 48) % 4) == 2) ? 0 : pick_gap();
    if (gap > 0) begin
      echo_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    echo_valid <= 1'b1;
    echo_ticks <= ticks;
    do begin
      @(posedge clk);
    end while (echo_stall);
    predicted = next_throttle(ticks);
    pending_cmds.push_back(known ? typed : predicted);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    echo_valid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_SWITCH_HEIGHT: cfg_switch = data[DIST_W-1:0];
      REG_KILL_HEIGHT:   cfg_kill = data[DIST_W-1:0];
      REG_VALID_LIMIT:   cfg_vlim = data[DIST_W-1:0];
      REG_WIDTH_CEILING: cfg_ceiling = data[WIDTH_W-1:0];
      REG_HOVER_ITEMS:   cfg_hover = data[HOVER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_phase(int p);
    logic [CFG_DATA_W-1:0] sw;
    logic [CFG_DATA_W-1:0] kl;
    logic [CFG_DATA_W-1:0] vl;
    logic [CFG_DATA_W-1:0] ce;
    logic [CFG_DATA_W-1:0] hv;
    logic [CFG_IDX_W-1:0]  spare;
    case (p)
      0: begin
        sw = 16'd0; kl = 16'd0; vl = 16'd0; ce = 16'd0; hv = 16'd0;
      end
      1: begin
        sw = 16'd1600; kl = 16'd1600; vl = 16'd1800; ce = 16'hFFFF; hv = 16'd255;
      end
      2: begin
        sw = CFG_DATA_W'(RST_SWITCH_HEIGHT); kl = CFG_DATA_W'(RST_KILL_HEIGHT);
        vl = CFG_DATA_W'(RST_VALID_LIMIT);
        ce = RST_WIDTH_CEILING; hv = CFG_DATA_W'(RST_HOVER_ITEMS);
      end
      default: begin
        sw = CFG_DATA_W'($urandom_range(0, 1600));
        kl = CFG_DATA_W'($urandom_range(0, 1600));
        vl = CFG_DATA_W'($urandom_range(0, 1800));
        ce = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                         : CFG_DATA_W'($urandom_range(5000, 10000));
        hv = CFG_DATA_W'($urandom_range(0, 255));
      end
    endcase
    spare = CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
    drain();
    repeat (2) @(negedge clk);
    write_reg(REG_SWITCH_HEIGHT, sw);
    write_reg(REG_KILL_HEIGHT, kl);
    write_reg(REG_VALID_LIMIT, vl);
    write_reg(REG_WIDTH_CEILING, ce);
    write_reg(REG_HOVER_ITEMS, hv);
    write_reg(spare, CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off.
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        stall_left = (((results_seen / 64) % 3) == 1) ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_cmds.size() == 0) begin
        $display("%0t: result with no request pending: width %0d mode %0d dist %0d",
                 $time, high_width, mode, distance);
        errors++;
      end else begin
        want_cmd = pending_cmds.pop_front();
        check_field("high_width", want_cmd.width, high_width);
        check_field("mode", 16'(want_cmd.mode), 16'(mode));
        check_field("distance", 16'(want_cmd.dist_used), 16'(distance));
        check_field("rejected", 16'(want_cmd.rej), 16'(rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("altitude_flight_mode_throttle_test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    echo_valid = 1'b0;
    echo_ticks = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_switch = RST_SWITCH_HEIGHT;
    cfg_kill = RST_KILL_HEIGHT;
    cfg_vlim = RST_VALID_LIMIT;
    cfg_ceiling = RST_WIDTH_CEILING;
    cfg_hover = RST_HOVER_ITEMS;
    mode_now = MODE_TAKEOFF;
    dist_hold = '0;
    width_hold = '0;
    hover_steps = '0;
    plan = '{
      '{ROW_ECHO, '0, 16'd0,     1'b1, '{16'd0,     MODE_TAKEOFF, 11'd0,  1'b0}},
      '{ROW_ECHO, '0, 16'hFFFF,  1'b1, '{16'd0,     MODE_TAKEOFF, 11'd0,  1'b1}},
      '{ROW_ECHO, '0, 16'd592,   1'b1, '{16'd9000,  MODE_TAKEOFF, 11'd16, 1'b0}},
      '{ROW_ECHO, '0, 16'd37,    1'b1, '{16'd9000,  MODE_TAKEOFF, 11'd1,  1'b0}},
      '{ROW_ECHO, '0, 16'd36,    1'b1, '{16'd9000,  MODE_TAKEOFF, 11'd0,  1'b0}},
      '{ROW_CFG, REG_WIDTH_CEILING, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd37,    1'b1, '{16'd54000, MODE_TAKEOFF, 11'd1,  1'b0}},
      '{ROW_ECHO, '0, 16'd17760, 1'b0, NO_TYPED},
      '{ROW_CFG, REG_KILL_HEIGHT, 16'd400, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd17000, 1'b0, NO_TYPED},
      '{ROW_CFG, REG_KILL_HEIGHT, 16'd960, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd17797, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd35557, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'hFFFF,  1'b0, NO_TYPED},
      '{ROW_CFG, REG_HOVER_ITEMS, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd20000, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd0,     1'b1, '{16'd5600,  MODE_LANDING, 11'd0,  1'b0}},
      '{ROW_CFG, REG_VALID_LIMIT, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'hFFFF,  1'b0, NO_TYPED},
      '{ROW_CFG, REG_KILL_HEIGHT, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'hFFFF,  1'b0, NO_TYPED},
      '{ROW_CFG, REG_WIDTH_CEILING, 16'd9000, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'hFFFF,  1'b0, NO_TYPED},
      '{ROW_CFG, REG_UNUSED_HI, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_CFG, REG_SWITCH_HEIGHT, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ECHO, '0, 16'd0,     1'b0, NO_TYPED}
    };
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_echo(plan[i].value, plan[i].known, plan[i].res);
      end
    end
    for (int p = 0; p < PHASES; p++) begin
      setup_phase(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == 50) begin
          hold_off_req = 1'b1;
        end
        if (p == 4 && n == 100) begin
          // Let the block run dry before the next request.
          drain();
          @(negedge clk);
        end
        send_echo(pick_ticks(), 1'b0, NO_TYPED);
      end
    end
    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("altitude_flight_mode_throttle_test passed");
    end else begin
      $display("altitude_flight_mode_throttle_test failed");
    end
    $finish;
  end

endmodule

// File: altitude_flight_mode_throttle.f
hdl/afmt_pkg.sv
hdl/afmt_ucode_rom.sv
hdl/afmt_div.sv
hdl/altitude_flight_mode_throttle.sv
test/altitude_flight_mode_throttle_test.sv
